// File: design/fsbr_pkg.sv
package fsbr_pkg;

  // Reset value of the frame start timeout, in sample ticks.
  localparam logic [15:0] TIMEOUT_RESET = 16'd5100;

  // Bit counter codes within one byte.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] ACK_INDEX     = 4'd9;
  localparam logic [3:0] FIRST_BIT     = 4'd1;

  // One sample of the three serial pins.
  typedef struct packed {
    logic frame_level;
    logic clock_level;
    logic data_level;
  } sample_t;

  // One result per sample.
  typedef struct packed {
    logic       data_release;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       frame_done;
    logic [7:0] frame_length;
    logic       timed_out;
  } result_t;

endpackage

// File: design/fsbr_core.sv
module fsbr_core import fsbr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  sample_t     sample,
  input  logic [15:0] timeout_ticks,
  output result_t     result
);

  typedef enum logic [1:0] {
    PH_WAIT_FRAME   = 2'd0,
    PH_WAIT_CLK_LOW = 2'd1,
    PH_RECEIVE      = 2'd2
  } phase_t;

  localparam logic [7:0] MAX_COUNT = 8'(MAX_FRAME_BYTES);

  phase_t      phase, phase_next;
  logic [15:0] wait_count, wait_count_next;
  logic        prev_clock;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [7:0]  byte_count, byte_count_next;
  logic        ack_drive, ack_drive_next;

  logic        rise, fall, boundary;
  logic [16:0] wait_inc;

  assign rise     = !prev_clock && sample.clock_level;
  assign fall     = prev_clock && !sample.clock_level;
  assign boundary = (bit_index == 4'd0) || (bit_index == FIRST_BIT && sample.clock_level);
  assign wait_inc = {1'b0, wait_count} + 17'd1;

  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    byte_count_next = byte_count;
    ack_drive_next  = ack_drive;
    result          = '0;

    unique case (phase)
      PH_WAIT_CLK_LOW: begin
        if (!sample.frame_level) begin
          result.frame_done = 1'b1;
          phase_next        = PH_WAIT_FRAME;
          wait_count_next   = '0;
          bit_index_next    = '0;
          shift_byte_next   = '0;
          byte_count_next   = '0;
          ack_drive_next    = 1'b1;
        end else if (!sample.clock_level) begin
          phase_next      = PH_RECEIVE;
          bit_index_next  = '0;
          shift_byte_next = '0;
        end
      end
      PH_RECEIVE: begin
        if (!sample.frame_level && boundary) begin
          result.frame_done   = 1'b1;
          result.frame_length = byte_count;
          phase_next          = PH_WAIT_FRAME;
          wait_count_next     = '0;
          bit_index_next      = '0;
          shift_byte_next     = '0;
          byte_count_next     = '0;
          ack_drive_next      = 1'b1;
        end else if (rise) begin
          if (bit_index < BITS_PER_BYTE) begin
            shift_byte_next = {shift_byte[6:0], sample.data_level};
            bit_index_next  = bit_index + 4'd1;
          end else if (bit_index == BITS_PER_BYTE && !ack_drive) begin
            result.byte_valid = 1'b1;
            result.byte_value = shift_byte;
            bit_index_next    = ACK_INDEX;
          end
        end else if (fall) begin
          if (bit_index == BITS_PER_BYTE && ack_drive) begin
            ack_drive_next = 1'b0;
          end else if (bit_index == ACK_INDEX) begin
            ack_drive_next = 1'b1;
            if (byte_count < MAX_COUNT) begin
              byte_count_next = byte_count + 8'd1;
            end
            bit_index_next  = '0;
            shift_byte_next = '0;
          end
        end
      end
      default: begin
        // Waiting for frame start; the unused code behaves the same way.
        if (!sample.frame_level) begin
          wait_count_next = wait_inc[15:0];
          if (wait_inc >= {1'b0, timeout_ticks}) begin
            result.frame_done = 1'b1;
            result.timed_out  = 1'b1;
            phase_next        = PH_WAIT_FRAME;
            wait_count_next   = '0;
            bit_index_next    = '0;
            shift_byte_next   = '0;
            byte_count_next   = '0;
            ack_drive_next    = 1'b1;
          end
        end else begin
          wait_count_next = '0;
          bit_index_next  = '0;
          shift_byte_next = '0;
          byte_count_next = '0;
          ack_drive_next  = 1'b1;
          phase_next      = sample.clock_level ? PH_WAIT_CLK_LOW : PH_RECEIVE;
        end
      end
    endcase

    result.data_release = ack_drive_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT_FRAME;
      wait_count <= '0;
      prev_clock <= 1'b1;
      bit_index  <= '0;
      shift_byte <= '0;
      byte_count <= '0;
      ack_drive  <= 1'b1;
    end else if (step) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      prev_clock <= sample.clock_level;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      byte_count <= byte_count_next;
      ack_drive  <= ack_drive_next;
    end
  end

endmodule

// File: design/framed_serial_byte_receiver.sv
// Framed serial byte receiver. Each input transfer carries one sample of the
// frame, serial clock and serial data pins, and each sample yields exactly
// one output transfer: the data line drive (0 pulls the line low as the
// acknowledge), a received byte when one completes, and an end-of-frame
// report with the byte count or a timeout flag. Bytes arrive most significant
// bit first on serial clock rising edges. The block takes one sample per
// clock cycle while the input is not stalled. A sample is held in the input
// register, and its result is then presented from the result register, so
// the output transfer follows the input transfer through both registers.
// The receiver state is updated as the sample moves between the two
// registers. The input stalls only while both registers are full and the
// output is stalled. The timeout register may be written only while no
// samples are in flight.
module framed_serial_byte_receiver import fsbr_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst,

  // Sample input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        frame_level,
  input  logic        clock_level,
  input  logic        data_level,

  // Result output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        data_release,
  output logic        byte_valid,
  output logic [7:0]  byte_value,
  output logic        frame_done,
  output logic [7:0]  frame_length,
  output logic        timed_out,

  // Timeout register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] timeout_ticks
);

  logic        in_full;
  sample_t     in_sample;
  logic        out_full;
  result_t     out_result;
  result_t     core_result;
  logic        out_free;
  logic        advance;
  logic [15:0] timeout;

  // The result register frees up when it is empty or its transfer completes
  // this cycle. The held sample advances whenever the result register is free,
  // and the input register then takes a new sample in the same cycle.
  assign out_free = !out_full || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;

  // Writes are always taken; only the user keeps register changes to idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout <= timeout_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_sample <= '{frame_level: frame_level, clock_level: clock_level,
                     data_level: data_level};
    end
  end

  // Receiver state and per-sample decode. The state steps exactly once for
  // each sample, at the edge where that sample enters the result register.
  fsbr_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .sample        (in_sample),
    .timeout_ticks (timeout),
    .result        (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_free) begin
      out_full <= advance;
    end
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign out_valid    = out_full;
  assign data_release = out_result.data_release;
  assign byte_valid   = out_result.byte_valid;
  assign byte_value   = out_result.byte_value;
  assign frame_done   = out_result.frame_done;
  assign frame_length = out_result.frame_length;
  assign timed_out    = out_result.timed_out;

endmodule
